/* hw/rtl/cng_pkg.sv */
`timescale 1ns / 1ps

package cng_pkg;

   localparam int FRAC       = 24;
   localparam int COEF_W     = 27;
   localparam int WHITE_W    = 25;
   localparam int TAP_N      = 7;
   localparam int TAP_IDX_W  = 3;
   localparam int STEP_W     = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic        CSR_SEED_IDX = 1'b0;
   localparam logic [31:0] SEED_RESET   = 32'd1;
   localparam logic [31:0] LCG_MUL      = 32'd1664525;
   localparam logic [31:0] LCG_INC      = 32'd1013904223;

   typedef logic signed [COEF_W-1:0] coef_type;

   localparam coef_type K_DIRECT    = 27'sd8995943;
   localparam coef_type K_TAP6      = 27'sd1944916;
   localparam coef_type K_PINK_OUT  = 27'sd1845494;
   localparam coef_type K_BROWN_IN  = 27'sd335544;
   localparam coef_type K_INV_102   = 27'sd16448251;
   localparam coef_type K_BROWN_OUT = 27'sd58720256;
   localparam coef_type K_WHITE_OUT = 27'sd5872026;

   typedef enum logic [1:0] {
      COLOR_WHITE     = 2'd0,
      COLOR_PINK      = 2'd1,
      COLOR_BROWN     = 2'd2,
      COLOR_ALT_WHITE = 2'd3
   } color_type;

   typedef enum logic [2:0] {
      SRC_WHITE,
      SRC_TAP,
      SRC_BROWN,
      SRC_TMP,
      SRC_SUM
   } src_type;

   typedef enum logic [3:0] {
      CF_KEEP,
      CF_GAIN,
      CF_DIRECT,
      CF_TAP6,
      CF_PINK_OUT,
      CF_BROWN_IN,
      CF_INV_102,
      CF_BROWN_OUT,
      CF_WHITE_OUT
   } coef_sel_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SUM_INIT,
      OP_TMP_LOAD,
      OP_TAP_STORE,
      OP_TAP6_STORE,
      OP_BROWN_ADD,
      OP_BROWN_STORE
   } op_type;

   typedef struct packed {
      logic                 lcg_step;
      logic                 mul_en;
      src_type              src;
      coef_sel_type         coef;
      op_type               op;
      logic [TAP_IDX_W-1:0] idx;
      logic                 load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic coef_type tap_keep(input logic [TAP_IDX_W-1:0] idx);
      coef_type c;
      unique case (idx)
         3'd0: c = 27'sd16758090;
         3'd1: c = 27'sd16665144;
         3'd2: c = 27'sd16257122;
         3'd3: c = 27'sd14537458;
         3'd4: c = 27'sd9227469;
         3'd5: c = -27'sd12777528;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic coef_type tap_gain(input logic [TAP_IDX_W-1:0] idx);
      coef_type c;
      unique case (idx)
         3'd0: c = 27'sd931436;
         3'd1: c = 27'sd1259565;
         3'd2: c = 27'sd2581208;
         3'd3: c = 27'sd5209084;
         3'd4: c = 27'sd8941454;
         3'd5: c = -27'sd283501;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic coef_type coef_value(input coef_sel_type sel,
                                           input logic [TAP_IDX_W-1:0] idx);
      coef_type c;
      unique case (sel)
         CF_KEEP:      c = tap_keep(idx);
         CF_GAIN:      c = tap_gain(idx);
         CF_DIRECT:    c = K_DIRECT;
         CF_TAP6:      c = K_TAP6;
         CF_PINK_OUT:  c = K_PINK_OUT;
         CF_BROWN_IN:  c = K_BROWN_IN;
         CF_INV_102:   c = K_INV_102;
         CF_BROWN_OUT: c = K_BROWN_OUT;
         CF_WHITE_OUT: c = K_WHITE_OUT;
         default:      c = '0;
      endcase
      return c;
   endfunction

endpackage

/* hw/rtl/cng_ctrl.sv */
`timescale 1ns / 1ps

module cng_ctrl import cng_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_color,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LCG,
      ST_RUN,
      ST_FLUSH,
      ST_PUSH
   } state_type;

   localparam logic [STEP_W-1:0] WHITE_LAST     = 5'd0;
   localparam logic [STEP_W-1:0] BROWN_DIV_STEP = 5'd3;
   localparam logic [STEP_W-1:0] BROWN_LAST     = 5'd6;
   localparam logic [STEP_W-1:0] PINK_PAIR_END  = 5'd12;
   localparam logic [STEP_W-1:0] PINK_TAP6_STEP = 5'd13;
   localparam logic [STEP_W-1:0] PINK_LAST      = 5'd16;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   color_type         color_ff;
   logic              req_ready_ff;

   logic [STEP_W-1:0] last_step;
   logic [STEP_W-1:0] step_m1;

   assign req_ready = req_ready_ff;
   assign step_m1   = step_ff - STEP_W'(1);

   always_comb begin
      unique case (color_ff)
         COLOR_PINK:      last_step = PINK_LAST;
         COLOR_BROWN:     last_step = BROWN_LAST;
         COLOR_WHITE:     last_step = WHITE_LAST;
         COLOR_ALT_WHITE: last_step = WHITE_LAST;
         default:         last_step = WHITE_LAST;
      endcase
   end

   // issue schedule; each product passes through the lo/hi and mres registers before its result is used
   always_comb begin
      cmd          = '0;
      cmd.src      = SRC_WHITE;
      cmd.coef     = CF_WHITE_OUT;
      cmd.op       = OP_NONE;
      cmd.lcg_step = (state_ff == ST_LCG);
      cmd.load_out = (state_ff == ST_PUSH) && status.out_free;
      if (state_ff == ST_RUN) begin
         unique case (color_ff)
            COLOR_PINK: begin
               priority if (step_ff == '0) begin
                  cmd.mul_en = 1'b1;
                  cmd.coef   = CF_DIRECT;
                  cmd.op     = OP_SUM_INIT;
               end else if (step_ff <= PINK_PAIR_END) begin
                  cmd.mul_en = 1'b1;
                  cmd.idx    = step_m1[TAP_IDX_W:1];
                  if (step_ff[0]) begin
                     cmd.src  = SRC_TAP;
                     cmd.coef = CF_KEEP;
                     cmd.op   = OP_TMP_LOAD;
                  end else begin
                     cmd.coef = CF_GAIN;
                     cmd.op   = OP_TAP_STORE;
                  end
               end else if (step_ff == PINK_TAP6_STEP) begin
                  cmd.mul_en = 1'b1;
                  cmd.coef   = CF_TAP6;
                  cmd.op     = OP_TAP6_STORE;
               end else if (step_ff == PINK_LAST) begin
                  cmd.mul_en = 1'b1;
                  cmd.src    = SRC_SUM;
                  cmd.coef   = CF_PINK_OUT;
               end else begin
                  cmd.mul_en = 1'b0;
               end
            end
            COLOR_BROWN: begin
               priority if (step_ff == '0) begin
                  cmd.mul_en = 1'b1;
                  cmd.coef   = CF_BROWN_IN;
                  cmd.op     = OP_BROWN_ADD;
               end else if (step_ff == BROWN_DIV_STEP) begin
                  cmd.mul_en = 1'b1;
                  cmd.src    = SRC_TMP;
                  cmd.coef   = CF_INV_102;
                  cmd.op     = OP_BROWN_STORE;
               end else if (step_ff == BROWN_LAST) begin
                  cmd.mul_en = 1'b1;
                  cmd.src    = SRC_BROWN;
                  cmd.coef   = CF_BROWN_OUT;
               end else begin
                  cmd.mul_en = 1'b0;
               end
            end
            COLOR_WHITE, COLOR_ALT_WHITE: begin
               cmd.mul_en = (step_ff == '0);
            end
            default: begin
               cmd.mul_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         color_ff     <= COLOR_WHITE;
         req_ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  color_ff     <= color_type'(req_color);
                  req_ready_ff <= 1'b0;
                  state_ff     <= ST_LCG;
               end
            end
            ST_LCG: begin
               step_ff  <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == last_step) begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               state_ff <= ST_PUSH;
            end
            ST_PUSH: begin
               // hold until the output register can take the sample
               if (status.out_free) begin
                  req_ready_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/cng_dp.sv */
`timescale 1ns / 1ps

module cng_dp import cng_pkg::*; #(
   parameter int OUT_WIDTH = 24,
   parameter int ACC_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   input  cmd_type                     cmd,
   output status_type                  status,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_WIDTH-1:0] rsp_sample
);

   localparam int OPW     = ACC_WIDTH + 3;
   localparam int HIW     = OPW - FRAC;
   localparam int LOW_P   = FRAC + 1 + COEF_W;
   localparam int HIP     = HIW + COEF_W;
   localparam int RW      = OPW + 4;
   localparam int EW      = RW + 12;
   localparam int RS      = (OUT_WIDTH <= 29) ? (29 - OUT_WIDTH) : 0;
   localparam int LS      = (OUT_WIDTH > 29) ? (OUT_WIDTH - 29) : 0;
   localparam int RS_HALF = (1 << RS) >> 1;

   localparam logic signed [RW-1:0] ACC_MAX = {{(RW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [RW-1:0] ACC_MIN = ~ACC_MAX;
   localparam logic signed [EW-1:0] V40_MAX = {{(EW-39){1'b0}}, {39{1'b1}}};
   localparam logic signed [EW-1:0] V40_MIN = ~V40_MAX;
   localparam logic signed [EW-1:0] OUT_MAX = {{(EW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [EW-1:0] OUT_MIN = ~OUT_MAX;

   logic [31:0]                  seed_ff;
   logic [31:0]                  lcg_ff;
   logic signed [ACC_WIDTH-1:0]  taps_ff [TAP_N];
   logic signed [ACC_WIDTH-1:0]  brown_ff;
   logic signed [RW-1:0]         tmp_ff;
   logic signed [OPW-1:0]        sum_ff;
   logic signed [ACC_WIDTH-1:0]  newtap_ff;
   logic                         newtap_vld_ff;
   logic signed [LOW_P-1:0]      lo_ff;
   logic signed [HIP-1:0]        hi_ff;
   logic signed [RW-1:0]         mres_ff;
   logic                         op1_vld_ff;
   op_type                       op1_op_ff;
   logic [TAP_IDX_W-1:0]         op1_idx_ff;
   logic                         op2_vld_ff;
   op_type                       op2_op_ff;
   logic [TAP_IDX_W-1:0]         op2_idx_ff;
   logic signed [OUT_WIDTH-1:0]  rsp_sample_ff;
   logic                         rsp_valid_ff;

   logic [31:0]                  lcg_in;
   logic signed [WHITE_W-1:0]    white;
   logic signed [OPW-1:0]        opa;
   coef_type                     coef;
   logic signed [LOW_P-1:0]      lo_in;
   logic signed [HIP-1:0]        hi_in;
   logic signed [LOW_P-1:0]      lo_rnd;
   logic signed [RW-1:0]         mres_in;
   logic signed [RW-1:0]         pair_sum;
   logic signed [ACC_WIDTH-1:0]  tap_new;
   logic signed [OUT_WIDTH-1:0]  sample_in;
   logic                         cfg_wr;
   logic                         cfg_hit;

   function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [RW-1:0] v);
      logic signed [ACC_WIDTH-1:0] r;
      if (v > ACC_MAX) begin
         r = ACC_WIDTH'(ACC_MAX);
      end else if (v < ACC_MIN) begin
         r = ACC_WIDTH'(ACC_MIN);
      end else begin
         r = ACC_WIDTH'(v);
      end
      return r;
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [RW-1:0] v);
      logic signed [EW-1:0] ve;
      logic signed [EW-1:0] vs;
      logic signed [OUT_WIDTH-1:0] r;
      ve = EW'(v);
      if (RS > 0) begin
         vs = (ve + EW'(RS_HALF)) >>> RS;
      end else begin
         if (ve > V40_MAX) begin
            ve = V40_MAX;
         end else if (ve < V40_MIN) begin
            ve = V40_MIN;
         end
         vs = ve <<< LS;
      end
      if (vs > OUT_MAX) begin
         r = OUT_WIDTH'(OUT_MAX);
      end else if (vs < OUT_MIN) begin
         r = OUT_WIDTH'(OUT_MIN);
      end else begin
         r = OUT_WIDTH'(vs);
      end
      return r;
   endfunction

   assign cfg_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_SEED_IDX);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && cfg_hit;
   assign csr_prdata = cfg_hit ? seed_ff : '0;

   assign lcg_in = lcg_ff * LCG_MUL + LCG_INC;
   // (x - 2^31) >> 7 with floor: flip the top bit and drop seven
   assign white  = $signed({~lcg_ff[31], lcg_ff[30:7]});

   always_comb begin
      unique case (cmd.src)
         SRC_WHITE: opa = OPW'(white);
         SRC_TAP:   opa = OPW'(taps_ff[cmd.idx]);
         SRC_BROWN: opa = OPW'(brown_ff);
         SRC_TMP:   opa = $signed(tmp_ff[OPW-1:0]);
         SRC_SUM:   opa = sum_ff;
         default:   opa = '0;
      endcase
   end

   // split the operand at the binary point: low part unsigned, high part signed
   assign coef    = coef_value(cmd.coef, cmd.idx);
   assign lo_in   = $signed({1'b0, opa[FRAC-1:0]}) * coef;
   assign hi_in   = $signed(opa[OPW-1:FRAC]) * coef;
   assign lo_rnd  = (lo_ff + LOW_P'(1 << (FRAC - 1))) >>> FRAC;
   assign mres_in = RW'(hi_ff) + RW'(lo_rnd);

   assign pair_sum  = tmp_ff + mres_ff;
   assign tap_new   = sat_acc(pair_sum);
   assign sample_in = to_out(mres_ff);

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= SEED_RESET;
         lcg_ff        <= SEED_RESET;
         brown_ff      <= '0;
         for (int i = 0; i < TAP_N; i++) begin
            taps_ff[i] <= '0;
         end
         op1_vld_ff    <= 1'b0;
         op2_vld_ff    <= 1'b0;
         newtap_vld_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         op1_vld_ff    <= cmd.mul_en;
         op2_vld_ff    <= op1_vld_ff;
         newtap_vld_ff <= op2_vld_ff && (op2_op_ff == OP_TAP_STORE);
         if (cmd.lcg_step) begin
            lcg_ff <= lcg_in;
         end
         if (op2_vld_ff) begin
            unique case (op2_op_ff)
               OP_TAP_STORE:   taps_ff[op2_idx_ff] <= tap_new;
               OP_TAP6_STORE:  taps_ff[TAP_N-1] <= sat_acc(mres_ff);
               OP_BROWN_STORE: brown_ff <= sat_acc(mres_ff);
               default: ;
            endcase
         end
         if (cfg_wr) begin
            seed_ff  <= csr_pwdata;
            lcg_ff   <= (csr_pwdata == '0) ? SEED_RESET : csr_pwdata;
            brown_ff <= '0;
            for (int i = 0; i < TAP_N; i++) begin
               taps_ff[i] <= '0;
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
         op1_op_ff  <= cmd.op;
         op1_idx_ff <= cmd.idx;
      end
      if (op1_vld_ff) begin
         mres_ff    <= mres_in;
         op2_op_ff  <= op1_op_ff;
         op2_idx_ff <= op1_idx_ff;
      end
      // fold each freshly stored tap into the pink sum in the cycle after its store
      if (newtap_vld_ff) begin
         sum_ff <= sum_ff + OPW'(newtap_ff);
      end
      if (op2_vld_ff) begin
         unique case (op2_op_ff)
            OP_SUM_INIT:  sum_ff <= OPW'(mres_ff) + OPW'(taps_ff[TAP_N-1]);
            OP_TMP_LOAD:  tmp_ff <= mres_ff;
            OP_BROWN_ADD: tmp_ff <= RW'(brown_ff) + mres_ff;
            OP_TAP_STORE: newtap_ff <= tap_new;
            default: ;
         endcase
      end
      if (cmd.load_out) begin
         rsp_sample_ff <= sample_in;
      end
   end

endmodule

/* hw/rtl/colored_noise_generator.sv */
`timescale 1ns / 1ps

// Colored noise source. Each req item advances a 32-bit LCG and returns one rsp item: white
// (req_color 0 or 3), pink through a seven-tap filter (1) or brown from a leaky integrator (2),
// as a signed sample with four integer bits and OUT_WIDTH-5 fraction bits. Internal state is
// ACC_WIDTH-bit fixed point with 24 fraction bits. One item is in work at a time; a finished
// sample waits in the output register while the next item is accepted. After acceptance an
// item steps the LCG, issues its products and flushes before its sample is loaded into the
// output register, and the next item can be accepted once the sample is loaded. The schedule
// is set by the single shared fixed-point multiplier, which starts one product per cycle,
// and by the brown path's chain of three dependent products. Writing the seed register (byte
// address 0) reloads the generator, zero loaded as one, and clears the pink and brown state;
// write it only while no item is in work.

module colored_noise_generator import cng_pkg::*; #(
   parameter int OUT_WIDTH = 24,
   parameter int ACC_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_color,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [OUT_WIDTH-1:0] rsp_sample,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;

   cng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_color (req_color),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cng_dp #(
      .OUT_WIDTH (OUT_WIDTH),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sample  (rsp_sample)
   );

endmodule

/* hw/rtl/cng_checker.sv */
`timescale 1ns / 1ps

module cng_checker #(
   parameter int OUT_WIDTH = 24
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [OUT_WIDTH-1:0] rsp_sample,
   input logic                        csr_psel,
   input logic                        csr_penable,
   input logic                        csr_pwrite,
   input logic [2:0]                  csr_paddr,
   input logic [31:0]                 csr_pwdata,
   input logic [31:0]                 csr_prdata
);

   logic [1:0] pend_ff;
   logic       req_acc;
   logic       rsp_acc;
   logic       seed_wr;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;
   assign seed_wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);

   // items accepted but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_acc) - 2'(rsp_acc);
      end
   end

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result shown with no item outstanding");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two items outstanding");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("second item taken while one is in work");

   a_seed_readback: assert property (@(posedge clock) disable iff (reset)
      seed_wr |=> (csr_paddr[2] != 1'b0) || (csr_prdata == $past(csr_pwdata)))
      else $error("seed read back differs from value written");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled result dropped or changed");

endmodule

bind colored_noise_generator cng_checker #(.OUT_WIDTH(OUT_WIDTH)) u_cng_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_sample  (rsp_sample),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);

/* tb/colored_noise_generator_tb.sv */
`timescale 1ns / 1ps

module colored_noise_generator_tb;
   import cng_pkg::*;

   localparam int OUT_W = 24;
   localparam int ACC_W = 32;
   localparam int OUT_SHIFT = 29 - OUT_W;
   localparam int PHASE_ITEMS = 72;
   localparam int RSP_HOLD_CYCLES = 120;
   localparam int IDLE_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 40;

   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR = {CSR_SEED_IDX, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

   localparam logic [31:0] LCG_A = 32'd1664525;
   localparam logic [31:0] LCG_C = 32'd1013904223;

   localparam longint PINK_DIRECT = 8995943;
   localparam longint PINK_TAP6 = 1944916;
   localparam longint PINK_GAIN = 1845494;
   localparam longint BROWN_IN = 335544;
   localparam longint BROWN_LEAK = 16448251;
   localparam longint BROWN_GAIN = 58720256;
   localparam longint WHITE_GAIN = 5872026;

   typedef enum {ROW_ITEM, ROW_SEED, ROW_UNMAPPED} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      color_type               color;
      logic [31:0]             data;
      bit                      pinned;
      logic signed [OUT_W-1:0] sample;
   } directed_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_color = 2'd0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]     rsp_sample;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_paddr = '0;
   logic [CSR_DATA_W-1:0]       csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]       csr_prdata;
   logic                        csr_pready;

   // generator and filter state as the block should hold it
   logic [31:0]                 seed_shadow = 32'd1;
   logic [31:0]                 lcg_state = 32'd1;
   longint                      pink_taps [0:6] = '{default: 0};
   longint                      brown_level = 0;

   logic signed [OUT_W-1:0]     pending_samples [$];
   logic signed [OUT_W-1:0]     model_sample;
   bit                          pin_valid = 1'b0;
   logic signed [OUT_W-1:0]     pin_sample = '0;
   bit                          req_gaps_on = 1'b1;
   bit                          rsp_gaps_on = 1'b1;
   bit                          hold_rsp_long = 1'b0;
   int                          error_count = 0;
   int                          idle_cycles = 0;

   directed_row_type            directed_rows [0:26];

   colored_noise_generator #(
      .OUT_WIDTH(OUT_W),
      .ACC_WIDTH(ACC_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_color  (req_color),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic longint keep_coef(input int i);
      case (i)
         0: return 16758090;
         1: return 16665144;
         2: return 16257122;
         3: return 14537458;
         4: return 9227469;
         default: return -12777528;
      endcase
   endfunction

   function automatic longint gain_coef(input int i);
      case (i)
         0: return 931436;
         1: return 1259565;
         2: return 2581208;
         3: return 5209084;
         4: return 8941454;
         default: return -283501;
      endcase
   endfunction

   // product with 24 fraction bits kept, rounded half up
   function automatic longint scale_q24(input longint a, input longint k);
      return (a * k + (64'sd1 <<< 23)) >>> 24;
   endfunction

   function automatic longint clamp_bits(input longint v, input int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic void load_seed_register(input logic [CSR_ADDR_W-1:0] addr,
                                              input logic [31:0] data);
      if (addr != SEED_ADDR) return;
      seed_shadow = data;
      lcg_state = (data == 32'd0) ? 32'd1 : data;
      for (int i = 0; i < 7; i++) pink_taps[i] = 0;
      brown_level = 0;
   endfunction

   function automatic logic signed [OUT_W-1:0] next_noise_sample(input logic [1:0] color);
      longint white;
      longint mixed;
      longint level;
      lcg_state = lcg_state * LCG_A + LCG_C;
      white = (longint'({32'd0, lcg_state}) - (64'sd1 <<< 31)) >>> 7;
      case (color)
         COLOR_PINK: begin
            for (int i = 0; i < 6; i++) begin
               pink_taps[i] = clamp_bits(scale_q24(pink_taps[i], keep_coef(i))
                                         + scale_q24(white, gain_coef(i)), ACC_W);
            end
            // last tap enters the sum with its old value
            mixed = scale_q24(white, PINK_DIRECT) + pink_taps[6];
            for (int i = 0; i < 6; i++) mixed += pink_taps[i];
            pink_taps[6] = clamp_bits(scale_q24(white, PINK_TAP6), ACC_W);
            level = scale_q24(mixed, PINK_GAIN);
         end
         COLOR_BROWN: begin
            brown_level = clamp_bits(scale_q24(brown_level + scale_q24(white, BROWN_IN),
                                               BROWN_LEAK), ACC_W);
            level = scale_q24(brown_level, BROWN_GAIN);
         end
         default: level = scale_q24(white, WHITE_GAIN);
      endcase
      level = (level + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      return OUT_W'(clamp_bits(level, OUT_W));
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_samples.size() == 0) begin
               note_error($sformatf("sample %0d with no item outstanding", rsp_sample));
            end else begin
               model_sample = pending_samples.pop_front();
               if (rsp_sample !== model_sample) begin
                  note_error($sformatf("sample expected %0d got %0d", model_sample, rsp_sample));
               end
            end
         end
         if (req_valid && req_ready) begin
            model_sample = next_noise_sample(req_color);
            pending_samples.push_back(pin_valid ? pin_sample : model_sample);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // result side: short random stalls, or one long hold when asked
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_rsp_long) begin
            hold_rsp_long = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(negedge clock);
         end else if (rsp_gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [1:0] color, input bit pinned,
                            input logic signed [OUT_W-1:0] pinned_val);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_color <= 2'($urandom_range(0, 3));
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_color <= color;
      pin_valid = pinned;
      pin_sample = pinned_val;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (is_write) begin
         load_seed_register(addr, data);
      end else if (csr_prdata !== seed_shadow) begin
         note_error($sformatf("seed readback expected %h got %h", seed_shadow, csr_prdata));
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_seed(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      drain_results();
      csr_access(1'b1, addr, data);
      csr_access(1'b0, SEED_ADDR, 32'd0);
   endtask

   initial begin : stimulus
      int sent;
      int run_len;
      logic [1:0] run_color;
      logic [31:0] phase_seed;

      // first step from seed one lands at white * 0.35 = -96721
      directed_rows = '{
         '{ROW_ITEM,     COLOR_WHITE,     32'h0,         1'b1, -24'sd96721},
         '{ROW_ITEM,     COLOR_PINK,      32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_BROWN,     32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_ALT_WHITE, 32'h0,         1'b0, '0},
         '{ROW_SEED,     COLOR_WHITE,     32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_ALT_WHITE, 32'h0,         1'b1, -24'sd96721},
         '{ROW_UNMAPPED, COLOR_WHITE,     32'hdead_beef, 1'b0, '0},
         '{ROW_ITEM,     COLOR_WHITE,     32'h0,         1'b0, '0},
         '{ROW_SEED,     COLOR_WHITE,     32'h1,         1'b0, '0},
         '{ROW_ITEM,     COLOR_WHITE,     32'h0,         1'b1, -24'sd96721},
         '{ROW_SEED,     COLOR_WHITE,     32'hffff_ffff, 1'b0, '0},
         '{ROW_ITEM,     COLOR_PINK,      32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_PINK,      32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_PINK,      32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_PINK,      32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_BROWN,     32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_BROWN,     32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_BROWN,     32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_WHITE,     32'h0,         1'b0, '0},
         '{ROW_SEED,     COLOR_WHITE,     32'h8000_0000, 1'b0, '0},
         '{ROW_ITEM,     COLOR_BROWN,     32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_BROWN,     32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_BROWN,     32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_PINK,      32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_PINK,      32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_PINK,      32'h0,         1'b0, '0},
         '{ROW_ITEM,     COLOR_ALT_WHITE, 32'h0,         1'b0, '0}
      };

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      csr_access(1'b0, SEED_ADDR, 32'd0);

      foreach (directed_rows[n]) begin
         case (directed_rows[n].kind)
            ROW_ITEM: send_item(directed_rows[n].color, directed_rows[n].pinned,
                                directed_rows[n].sample);
            ROW_SEED: write_seed(SEED_ADDR, directed_rows[n].data);
            default: write_seed(UNMAPPED_ADDR, directed_rows[n].data);
         endcase
      end

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: phase_seed = 32'hffff_ffff;
            3: phase_seed = 32'h0;
            default: phase_seed = $urandom;
         endcase
         write_seed(SEED_ADDR, phase_seed);
         req_gaps_on = (phase != 2) && (phase != 3) && (phase != 5);
         rsp_gaps_on = (phase != 1) && (phase != 5);
         if (phase == 3) begin
            // stall the result side long enough to back up the input
            @(posedge clock);
            hold_rsp_long = 1'b1;
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            run_color = ($urandom_range(0, 2) == 0) ? 2'(COLOR_PINK) : 2'($urandom_range(0, 3));
            run_len = $urandom_range(1, 16);
            repeat (run_len) begin
               send_item(run_color, 1'b0, '0);
               sent++;
            end
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_samples.size() != 0) begin
         note_error($sformatf("%0d samples never arrived", pending_samples.size()));
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/cng_pkg.sv
hw/rtl/cng_ctrl.sv
hw/rtl/cng_dp.sv
hw/rtl/colored_noise_generator.sv
hw/rtl/cng_checker.sv
tb/colored_noise_generator_tb.sv
